// ----- rtl/assert_macros.svh -----
// Assertion helpers for the verification module (spx_checker) of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define SPX_ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Concurrent assertion on the default clk and rst_n of the enclosing module.
`define SPX_ASSERT(lbl, prop, msg) `SPX_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ----- rtl/spx_pkg.sv -----
// ----------------------------------------------------------------------------
// spx_pkg
// Types, command codes and helper functions of the XOR sprite blitter.
// ----------------------------------------------------------------------------
package spx_pkg;

  localparam logic [2:0] MODE_INIT = 3'd0;
  localparam logic [2:0] MODE_DRAW = 3'd1;
  localparam logic [2:0] MODE_MOVE = 3'd2;
  localparam logic [2:0] MODE_HIT  = 3'd3;
  localparam logic [2:0] MODE_WPIX = 3'd4;
  localparam logic [2:0] MODE_RPIX = 3'd5;

  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_DRAW = 3'd1;
  localparam logic [2:0] OP_MOVE = 3'd2;
  localparam logic [2:0] OP_HIT  = 3'd3;
  localparam logic [2:0] OP_WPIX = 3'd4;
  localparam logic [2:0] OP_RPIX = 3'd5;
  localparam logic [2:0] OP_NOP  = 3'd6;

  localparam logic [1:0] KIND_REUSE = 2'd0;
  localparam logic [1:0] KIND_MUL   = 2'd1;
  localparam logic [1:0] KIND_PLAIN = 2'd2;

  localparam logic [7:0] COLL_FLAG = 8'h80;
  localparam logic [7:0] HIT_X     = 8'h01;
  localparam logic [7:0] HIT_Y     = 8'h02;
  localparam logic [7:0] COL_RESET = 8'hff;

  typedef struct packed {
    logic [2:0]        op;
    logic [4:0]        id;
    logic [15:0]       px;
    logic [15:0]       py;
    logic [7:0]        col;
    logic [63:0]       pat;
    logic [1:0]        kind;
    logic signed [1:0] wdx;
    logic signed [1:0] wdy;
  } cmd_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [1:0]  sx;
    logic [1:0]  sy;
    logic [7:0]  col;
    logic        vis;
    logic [63:0] bmp;
  } spr_t;

  localparam spr_t SPR_RESET = '{x: 16'd0, y: 16'd0, sx: 2'd0, sy: 2'd0,
                                 col: COL_RESET, vis: 1'b0, bmp: 64'd0};

  function automatic logic pat_bit(logic [63:0] bmp, logic [2:0] r, logic [2:0] c);
    return bmp[6'd63 - {r, c}];
  endfunction

  function automatic logic signed [1:0] step_dec(logic [1:0] v);
    return v[1] ? 2'sb11 : $signed({1'b0, v[0]});
  endfunction

  function automatic logic signed [1:0] word_step(logic [15:0] w);
    logic signed [1:0] s;
    if (w[15:8] > 8'h80) begin
      s = 2'sb11;
    end else if (w[7:0] == 8'd0) begin
      s = 2'sb00;
    end else begin
      s = 2'sb01;
    end
    return s;
  endfunction

  function automatic logic signed [1:0] step_mul(logic signed [1:0] a,
                                                 logic signed [1:0] b);
    logic signed [1:0] s;
    if (a == 2'sb00 || b == 2'sb00) begin
      s = 2'sb00;
    end else if (a == b) begin
      s = 2'sb01;
    end else begin
      s = 2'sb11;
    end
    return s;
  endfunction

endpackage

// ----- rtl/spx_ram.sv -----
// ----------------------------------------------------------------------------
// spx_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/spx_fifo.sv -----
// ----------------------------------------------------------------------------
// spx_fifo
// Two-entry command queue between the front end and the execution engine.
// ----------------------------------------------------------------------------
module spx_fifo
  import spx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cmd_t wr_cmd,
  output logic q_full,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic q_empty
);

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rd_cmd  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        wp_r <= ~wp_r;
      end
      if (rd) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ----- rtl/spx_front.sv -----
// ----------------------------------------------------------------------------
// spx_front
// Accepts commands, checks sprite ids and decodes move steps into a command.
// ----------------------------------------------------------------------------
module spx_front
  import spx_pkg::*;
#(
  parameter int SPRITE_COUNT = 32
) (
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_mode,
  input  logic [4:0]  in_sprite_id,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [7:0]  in_colour,
  input  logic [63:0] in_pattern,
  input  logic [7:0]  in_move_kind,
  input  logic        clearing,
  input  logic        q_full,
  output logic        q_wr,
  output cmd_t        q_cmd
);

  logic id_bad;

  assign full   = q_full || clearing;
  assign q_wr   = push && !full;
  assign id_bad = (32'(in_sprite_id) >= 32'(SPRITE_COUNT));

  always_comb begin
    q_cmd     = '0;
    q_cmd.id  = in_sprite_id;
    q_cmd.px  = in_pos_x;
    q_cmd.py  = in_pos_y;
    q_cmd.col = in_colour;
    q_cmd.pat = in_pattern;
    q_cmd.wdx = word_step(in_pos_x);
    q_cmd.wdy = word_step(in_pos_y);
    if (in_move_kind == 8'd0) begin
      q_cmd.kind = KIND_REUSE;
    end else if (in_move_kind == 8'd1) begin
      q_cmd.kind = KIND_MUL;
    end else begin
      q_cmd.kind = KIND_PLAIN;
    end
    unique case (in_mode)
      MODE_INIT: q_cmd.op = id_bad ? OP_NOP : OP_INIT;
      MODE_DRAW: q_cmd.op = id_bad ? OP_NOP : OP_DRAW;
      MODE_MOVE: q_cmd.op = id_bad ? OP_NOP : OP_MOVE;
      MODE_HIT:  q_cmd.op = id_bad ? OP_NOP : OP_HIT;
      MODE_WPIX: q_cmd.op = OP_WPIX;
      MODE_RPIX: q_cmd.op = OP_RPIX;
      default:   q_cmd.op = OP_NOP;
    endcase
  end

endmodule

// ----- rtl/spx_back.sv -----
// ----------------------------------------------------------------------------
// spx_back
// Execution engine: sprite table, framebuffer and the pixel sequencer.
// ----------------------------------------------------------------------------
module spx_back
  import spx_pkg::*;
#(
  parameter int SPRITE_COUNT  = 32,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       q_rd,
  output logic       clearing,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] read_data,
  output logic       display_updated
);

  localparam int FB_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int FB_AW    = $clog2(FB_DEPTH);
  localparam int TAW      = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;

  // Reciprocals that give exact quotients for every 16-bit position.
  localparam int MOD_KX  = 16 + $clog2(SCREEN_WIDTH);
  localparam int MOD_KY  = 16 + $clog2(SCREEN_HEIGHT);
  localparam int RECIP_X = ((1 << MOD_KX) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
  localparam int RECIP_Y = ((1 << MOD_KY) + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_TBL   = 4'd2;
  localparam logic [3:0] ST_MOD   = 4'd3;
  localparam logic [3:0] ST_SETUP = 4'd4;
  localparam logic [3:0] ST_SCAN  = 4'd5;
  localparam logic [3:0] ST_RMW   = 4'd6;
  localparam logic [3:0] ST_RPIX  = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  localparam logic [2:0] PH_ERASE = 3'd0;
  localparam logic [2:0] PH_DRAW  = 3'd1;
  localparam logic [2:0] PH_MOVE  = 3'd2;
  localparam logic [2:0] PH_HITX  = 3'd3;
  localparam logic [2:0] PH_HITY  = 3'd4;

  function automatic logic fits(logic [15:0] x, logic [15:0] y);
    return ((17'(x) + 17'd7) < 17'(SCREEN_WIDTH)) &&
           ((17'(y) + 17'd7) < 17'(SCREEN_HEIGHT));
  endfunction

  function automatic logic [15:0] sext16(logic signed [1:0] d);
    return {{14{d[1]}}, d};
  endfunction

  logic [3:0]         st_r, st_nxt;
  logic [2:0]         ph_r, ph_nxt;
  cmd_t               cmd_r;
  spr_t               ent_r, ent_nxt;
  logic               tv_rd_r;
  logic [SPRITE_COUNT-1:0] tvld_r;
  logic [FB_AW-1:0]   clr_cnt_r;
  logic [3:0]         mk_r, mk_nxt;
  logic [15:0]        remx_r, remx_nxt, remy_r, remy_nxt;
  logic signed [1:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [16:0] bx_r, bx_nxt, by_r, by_nxt;
  logic               w10_r, w10_nxt;
  logic [3:0]         wx_r, wx_nxt, wy_r, wy_nxt;
  logic [7:0]         swc_r, swc_nxt;
  logic [FB_AW-1:0]   addr_r;
  logic               hitx_r, hitx_nxt, hity_r, hity_nxt;
  logic [7:0]         rd_r, rd_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_rd_r, out_rd_nxt;
  logic               out_upd_r, out_upd_nxt;

  logic               fb_we;
  logic [FB_AW-1:0]   fb_waddr, fb_raddr;
  logic [7:0]         fb_wdata, fb_rdata;
  logic               tb_we;
  logic [TAW-1:0]     tb_waddr, tb_raddr;
  spr_t               tb_wdata, tb_rdata, ent_rd;

  logic signed [16:0] cx_s, cy_s;
  logic               cell_on, cell_touch, cell_last, sweep_end, ob, nb;
  logic signed [4:0]  nx_s, ny_s;
  logic [3:0]         lim;
  logic [FB_AW-1:0]   cell_addr, pix_addr;
  logic               pix_in;
  logic [33:0]        prodx, prody;
  logic [15:0]        ax, ay;
  logic signed [1:0]  mdx, mdy;

  spx_ram #(.WIDTH(8), .DEPTH(FB_DEPTH)) u_fb (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .raddr(fb_raddr), .rdata(fb_rdata)
  );

  spx_ram #(.WIDTH($bits(spr_t)), .DEPTH(SPRITE_COUNT)) u_tbl (
    .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .raddr(tb_raddr), .rdata(tb_rdata)
  );

  assign clearing        = (st_r == ST_CLR);
  assign empty           = !out_valid_r;
  assign read_data       = out_rd_r;
  assign display_updated = out_upd_r;
  assign tb_raddr        = TAW'(q_cmd.id);
  assign tb_waddr        = TAW'(cmd_r.id);
  assign ent_rd          = tv_rd_r ? tb_rdata : SPR_RESET;

  assign cx_s      = bx_r + $signed({13'd0, wx_r});
  assign cy_s      = by_r + $signed({13'd0, wy_r});
  assign cell_on   = !cx_s[16] && ($unsigned(cx_s) < 17'(SCREEN_WIDTH)) &&
                     !cy_s[16] && ($unsigned(cy_s) < 17'(SCREEN_HEIGHT));
  assign cell_addr = FB_AW'(FB_AW'($unsigned(cy_s)) * FB_AW'(SCREEN_WIDTH) +
                     FB_AW'($unsigned(cx_s)));
  assign lim       = w10_r ? 4'd9 : 4'd7;
  assign cell_last = (wx_r == lim) && (wy_r == lim);

  assign nx_s = $signed({1'b0, wx_r}) - 5'sd1 - {{3{dx_r[1]}}, dx_r};
  assign ny_s = $signed({1'b0, wy_r}) - 5'sd1 - {{3{dy_r[1]}}, dy_r};

  always_comb begin
    ob = 1'b0;
    if (wx_r >= 4'd1 && wx_r <= 4'd8 && wy_r >= 4'd1 && wy_r <= 4'd8) begin
      ob = pat_bit(ent_r.bmp, 3'(wy_r - 4'd1), 3'(wx_r - 4'd1));
    end
    nb = 1'b0;
    if (nx_s[4:3] == 2'b00 && ny_s[4:3] == 2'b00) begin
      nb = pat_bit(ent_r.bmp, ny_s[2:0], nx_s[2:0]);
    end
    if (ph_r == PH_MOVE) begin
      cell_touch = (ob != nb) && cell_on;
    end else begin
      cell_touch = pat_bit(ent_r.bmp, wy_r[2:0], wx_r[2:0]) && cell_on;
    end
  end

  assign pix_in   = (cmd_r.px < 16'(SCREEN_WIDTH)) && (cmd_r.py < 16'(SCREEN_HEIGHT));
  assign pix_addr = FB_AW'(FB_AW'(cmd_r.py) * FB_AW'(SCREEN_WIDTH) + FB_AW'(cmd_r.px));
  assign fb_raddr = (st_r == ST_TBL) ? pix_addr : cell_addr;

  assign prodx = 34'(cmd_r.px) * 34'(RECIP_X);
  assign prody = 34'(cmd_r.py) * 34'(RECIP_Y);
  assign ax    = ent_r.x + sext16(step_dec(ent_r.sx));
  assign ay    = ent_r.y + sext16(step_dec(ent_r.sy));

  always_comb begin
    mdx = cmd_r.wdx;
    mdy = cmd_r.wdy;
    unique case (cmd_r.kind)
      KIND_REUSE: begin
        if (cmd_r.wdx == 2'sb00 && cmd_r.wdy == 2'sb00) begin
          mdx = step_dec(ent_rd.sx);
          mdy = step_dec(ent_rd.sy);
        end
      end
      KIND_MUL: begin
        mdx = step_mul(cmd_r.wdx, step_dec(ent_rd.sx));
        mdy = step_mul(cmd_r.wdy, step_dec(ent_rd.sy));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    ph_nxt        = ph_r;
    ent_nxt       = ent_r;
    mk_nxt        = mk_r;
    remx_nxt      = remx_r;
    remy_nxt      = remy_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    w10_nxt       = w10_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    swc_nxt       = swc_r;
    hitx_nxt      = hitx_r;
    hity_nxt      = hity_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r && !pop;
    out_rd_nxt    = out_rd_r;
    out_upd_nxt   = out_upd_r;
    q_rd          = 1'b0;
    fb_we         = 1'b0;
    fb_waddr      = addr_r;
    fb_wdata      = fb_rdata ^ swc_r;
    tb_we         = 1'b0;
    tb_wdata      = ent_r;
    sweep_end     = 1'b0;

    unique case (st_r)
      ST_CLR: begin
        fb_we    = 1'b1;
        fb_waddr = clr_cnt_r;
        fb_wdata = 8'd0;
        if (clr_cnt_r == FB_AW'(FB_DEPTH - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_rd   = 1'b1;
          st_nxt = ST_TBL;
        end
      end
      ST_TBL: begin
        ent_nxt  = ent_rd;
        hitx_nxt = 1'b0;
        hity_nxt = 1'b0;
        rd_nxt   = 8'd0;
        wx_nxt   = 4'd0;
        wy_nxt   = 4'd0;
        unique case (cmd_r.op)
          OP_DRAW: begin
            mk_nxt   = 4'd1;
            remx_nxt = cmd_r.px;
            remy_nxt = cmd_r.py;
            st_nxt   = ST_MOD;
          end
          OP_MOVE: begin
            dx_nxt = mdx;
            dy_nxt = mdy;
            ph_nxt = PH_MOVE;
            st_nxt = ST_SETUP;
          end
          OP_HIT: begin
            ph_nxt = PH_HITX;
            st_nxt = ST_SETUP;
          end
          OP_WPIX: begin
            fb_we    = pix_in;
            fb_waddr = pix_addr;
            fb_wdata = cmd_r.col;
            st_nxt   = ST_DONE;
          end
          OP_RPIX: begin
            st_nxt = ST_RPIX;
          end
          default: begin
            st_nxt = ST_DONE;
          end
        endcase
      end
      ST_MOD: begin
        // Forms the quotients first, then the remainders from them.
        if (mk_r != 4'd0) begin
          remx_nxt = 16'(prodx >> MOD_KX);
          remy_nxt = 16'(prody >> MOD_KY);
          mk_nxt   = 4'd0;
        end else begin
          remx_nxt = cmd_r.px - 16'(32'(remx_r) * 32'(SCREEN_WIDTH));
          remy_nxt = cmd_r.py - 16'(32'(remy_r) * 32'(SCREEN_HEIGHT));
          ph_nxt   = PH_ERASE;
          st_nxt   = ST_SETUP;
        end
      end
      ST_SETUP: begin
        wx_nxt  = 4'd0;
        wy_nxt  = 4'd0;
        w10_nxt = 1'b0;
        unique case (ph_r)
          PH_ERASE: begin
            if (ent_r.vis && (ent_r.x != remx_r || ent_r.y != remy_r ||
                ent_r.col != cmd_r.col) && fits(ent_r.x, ent_r.y)) begin
              bx_nxt  = $signed({1'b0, ent_r.x});
              by_nxt  = $signed({1'b0, ent_r.y});
              swc_nxt = ent_r.col;
              st_nxt  = ST_SCAN;
            end else begin
              ph_nxt = PH_DRAW;
            end
          end
          PH_DRAW: begin
            if (fits(remx_r, remy_r)) begin
              bx_nxt  = $signed({1'b0, remx_r});
              by_nxt  = $signed({1'b0, remy_r});
              swc_nxt = cmd_r.col;
              st_nxt  = ST_SCAN;
            end else begin
              st_nxt = ST_DONE;
            end
          end
          PH_MOVE: begin
            if (fits(ent_r.x, ent_r.y)) begin
              bx_nxt  = $signed({1'b0, ent_r.x}) - 17'sd1;
              by_nxt  = $signed({1'b0, ent_r.y}) - 17'sd1;
              swc_nxt = ent_r.col;
              w10_nxt = 1'b1;
              st_nxt  = ST_SCAN;
            end else begin
              st_nxt = ST_DONE;
            end
          end
          PH_HITX: begin
            if (fits(ax, ent_r.y)) begin
              bx_nxt  = $signed({1'b0, ax});
              by_nxt  = $signed({1'b0, ent_r.y});
              swc_nxt = cmd_r.col;
              st_nxt  = ST_SCAN;
            end else begin
              ph_nxt = PH_HITY;
            end
          end
          default: begin
            if (fits(ent_r.x, ay)) begin
              bx_nxt  = $signed({1'b0, ent_r.x});
              by_nxt  = $signed({1'b0, ay});
              swc_nxt = cmd_r.col;
              st_nxt  = ST_SCAN;
            end else begin
              st_nxt = ST_DONE;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if (cell_touch) begin
          st_nxt = ST_RMW;
        end else begin
          sweep_end = cell_last;
        end
      end
      ST_RMW: begin
        st_nxt = ST_SCAN;
        if (ph_r == PH_HITX || ph_r == PH_HITY) begin
          if (fb_rdata == swc_r) begin
            sweep_end = 1'b1;
            if (ph_r == PH_HITX) begin
              hitx_nxt = 1'b1;
            end else begin
              hity_nxt = 1'b1;
            end
          end else begin
            sweep_end = cell_last;
          end
        end else begin
          fb_we     = 1'b1;
          sweep_end = cell_last;
        end
      end
      ST_RPIX: begin
        rd_nxt = pix_in ? fb_rdata : 8'd0;
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || pop) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = 8'd0;
          out_upd_nxt   = 1'b0;
          st_nxt        = ST_IDLE;
          unique case (cmd_r.op)
            OP_INIT: begin
              tb_we        = 1'b1;
              tb_wdata     = SPR_RESET;
              tb_wdata.bmp = cmd_r.pat;
            end
            OP_DRAW: begin
              tb_we        = 1'b1;
              tb_wdata.x   = remx_r;
              tb_wdata.y   = remy_r;
              tb_wdata.col = cmd_r.col;
              tb_wdata.vis = 1'b1;
              out_upd_nxt  = 1'b1;
            end
            OP_MOVE: begin
              tb_we       = 1'b1;
              tb_wdata.sx = dx_r;
              tb_wdata.sy = dy_r;
              tb_wdata.x  = ent_r.x + sext16(dx_r);
              tb_wdata.y  = ent_r.y + sext16(dy_r);
              out_upd_nxt = 1'b1;
            end
            OP_HIT: begin
              out_rd_nxt = COLL_FLAG | (hitx_r ? HIT_X : 8'd0) |
                           (hity_r ? HIT_Y : 8'd0);
            end
            OP_WPIX: begin
              out_upd_nxt = 1'b1;
            end
            OP_RPIX: begin
              out_rd_nxt = rd_r;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (st_r == ST_SCAN || st_r == ST_RMW) begin
      if (sweep_end) begin
        unique case (ph_r)
          PH_ERASE: begin
            ph_nxt = PH_DRAW;
            st_nxt = ST_SETUP;
          end
          PH_HITX: begin
            ph_nxt = PH_HITY;
            st_nxt = ST_SETUP;
          end
          default: begin
            st_nxt = ST_DONE;
          end
        endcase
      end else if (st_r == ST_RMW || !cell_touch) begin
        if (wx_r == lim) begin
          wx_nxt = 4'd0;
          wy_nxt = wy_r + 4'd1;
        end else begin
          wx_nxt = wx_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cmd_r   <= q_cmd;
      tv_rd_r <= tvld_r[tb_raddr];
    end
    if (st_r == ST_SCAN) begin
      addr_r <= cell_addr;
    end
    ent_r    <= ent_nxt;
    mk_r     <= mk_nxt;
    remx_r   <= remx_nxt;
    remy_r   <= remy_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    bx_r     <= bx_nxt;
    by_r     <= by_nxt;
    w10_r    <= w10_nxt;
    wx_r     <= wx_nxt;
    wy_r     <= wy_nxt;
    swc_r    <= swc_nxt;
    hitx_r   <= hitx_nxt;
    hity_r   <= hity_nxt;
    rd_r     <= rd_nxt;
    out_rd_r <= out_rd_nxt;
    out_upd_r <= out_upd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      ph_r        <= PH_ERASE;
      clr_cnt_r   <= '0;
      tvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
      if (st_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + FB_AW'(1);
      end
      if (tb_we) begin
        tvld_r[tb_waddr] <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/sprite_xor_blitter.sv -----
// ----------------------------------------------------------------------------
// sprite_xor_blitter
// XOR sprite engine for 8x8 one-bit sprites over an 8-bit framebuffer.
// ----------------------------------------------------------------------------
// After reset the framebuffer is cleared one pixel per cycle; full stays high
// until it finishes. Commands are queued two deep and executed one at a time
// by a sequencer around the framebuffer RAM: each window cell is scanned, and
// a touched cell's pixel is read and, except for collide, written back. A draw
// first reduces its position modulo the screen size, then sweeps the 8x8 image
// (after an erase sweep of the old image when needed); a move sweeps one 10x10
// window, and a collide up to two shifted 8x8 windows.
module sprite_xor_blitter
  import spx_pkg::*;
#(
  parameter int SPRITE_COUNT  = 32,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_mode,
  input  logic [4:0]  in_sprite_id,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [7:0]  in_colour,
  input  logic [63:0] in_pattern,
  input  logic [7:0]  in_move_kind,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_read_data,
  output logic        out_display_updated
);

  logic clearing, q_full, q_wr, q_rd, q_empty;
  cmd_t wr_cmd, rd_cmd;

  spx_front #(.SPRITE_COUNT(SPRITE_COUNT)) u_front (
    .push(push), .full(full), .in_mode(in_mode), .in_sprite_id(in_sprite_id),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_colour(in_colour),
    .in_pattern(in_pattern), .in_move_kind(in_move_kind), .clearing(clearing),
    .q_full(q_full), .q_wr(q_wr), .q_cmd(wr_cmd)
  );

  spx_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr(q_wr), .wr_cmd(wr_cmd), .q_full(q_full),
    .rd(q_rd), .rd_cmd(rd_cmd), .q_empty(q_empty)
  );

  spx_back #(
    .SPRITE_COUNT(SPRITE_COUNT), .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_cmd(rd_cmd), .q_rd(q_rd),
    .clearing(clearing), .pop(pop), .empty(empty), .read_data(out_read_data),
    .display_updated(out_display_updated)
  );

endmodule

// ----- rtl/spx_checker.sv -----
// ----------------------------------------------------------------------------
// spx_checker
// Port-level checks of the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_read_data,
  input logic       out_display_updated
);

  `SPX_ASSERT(a_clear_blocks, !$past(rst_n) |-> full, "input accepted during clear")
  `SPX_ASSERT(a_no_early_result, !$past(rst_n) |-> empty, "result right after reset")
  `SPX_ASSERT(a_upd_no_data, (!empty && out_display_updated) |-> (out_read_data == 8'h00), "update result carries data")
  `SPX_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(out_read_data)), "result dropped")

endmodule

bind sprite_xor_blitter spx_checker u_chk (.*);
